### src/planar_pose_compose_defines.svh
// ---------------------------------------------------------------------------
// planar pose compose assertion macros
// shared concurrent assertion forms for the port checker
// ---------------------------------------------------------------------------
`ifndef PLANAR_POSE_COMPOSE_DEFINES_SVH
`define PLANAR_POSE_COMPOSE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PPC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ppc assertion failed");

// next-cycle implication, checked outside reset
`define PPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ppc assertion failed");

`endif

### src/ppc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppc_pkg
// shared constants, types and the cordic arctangent table
// ---------------------------------------------------------------------------
package ppc_pkg;

    localparam int PPC_ANGLE_BITS = 16;
    localparam int CORDIC_STEPS   = 28;
    localparam int TW             = 34;   // cordic x/y width, q2.30 plus guard
    localparam int ZW             = 33;   // cordic residual angle width
    localparam int TRIG_SHIFT     = 30;
    localparam logic signed [TW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [1:0] OP_COMPOSE  = 2'd0;
    localparam logic [1:0] OP_INVERSE  = 2'd1;
    localparam logic [1:0] OP_RELATIVE = 2'd2;

    // operands riding along the cordic
    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         quad;
        logic signed [32:0] e;
        logic signed [32:0] f;
        logic signed [31:0] p;
        logic signed [31:0] q;
    } t_pay;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic [31:0] ppc_atan(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### src/ppc_cordic.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppc_cordic
// rotation-mode cordic, one micro-rotation per register stage
// ---------------------------------------------------------------------------
module ppc_cordic import ppc_pkg::*; #(
    parameter int PW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [ZW-1:0] i_z,
    input  logic [PW-1:0]        i_pay,
    output logic                 o_valid,
    output logic signed [TW-1:0] o_x,
    output logic signed [TW-1:0] o_y,
    output logic [PW-1:0]        o_pay
);

    logic                 r_v [CORDIC_STEPS];
    logic signed [TW-1:0] r_x [CORDIC_STEPS];
    logic signed [TW-1:0] r_y [CORDIC_STEPS];
    logic signed [ZW-1:0] r_z [CORDIC_STEPS];
    logic [PW-1:0]        r_p [CORDIC_STEPS];

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_stage
            logic                 w_v;
            logic signed [TW-1:0] w_x, w_y, n_x, n_y;
            logic signed [ZW-1:0] w_z, n_z;
            logic [PW-1:0]        w_p;
            localparam logic signed [ZW-1:0] ATAN = ZW'(ppc_atan(i));

            if (i == 0) begin : g_first
                assign w_v = i_valid;
                assign w_x = CORDIC_GAIN;
                assign w_y = '0;
                assign w_z = i_z;
                assign w_p = i_pay;
            end else begin : g_next
                assign w_v = r_v[i-1];
                assign w_x = r_x[i-1];
                assign w_y = r_y[i-1];
                assign w_z = r_z[i-1];
                assign w_p = r_p[i-1];
            end

            always_comb begin
                if (!w_z[ZW-1]) begin
                    n_x = w_x - (w_y >>> i);
                    n_y = w_y + (w_x >>> i);
                    n_z = w_z - ATAN;
                end else begin
                    n_x = w_x + (w_y >>> i);
                    n_y = w_y - (w_x >>> i);
                    n_z = w_z + ATAN;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[i] <= 1'b0;
                end else if (i_en) begin
                    r_v[i] <= w_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[i] <= n_x;
                    r_y[i] <= n_y;
                    r_z[i] <= n_z;
                    r_p[i] <= w_p;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[CORDIC_STEPS-1];
    assign o_x     = r_x[CORDIC_STEPS-1];
    assign o_y     = r_y[CORDIC_STEPS-1];
    assign o_pay   = r_p[CORDIC_STEPS-1];

endmodule

### src/ppc_combine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppc_combine
// quadrant fold, products, sums, rounding and saturation
// ---------------------------------------------------------------------------
module ppc_combine import ppc_pkg::*; #(
    parameter int ANGLE_BITS = PPC_ANGLE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [TW-1:0]  i_x,
    input  logic signed [TW-1:0]  i_y,
    input  t_pay                  i_pay,
    input  logic [ANGLE_BITS-1:0] i_rh,
    output logic                  o_valid,
    output logic [31:0]           o_rx,
    output logic [31:0]           o_ry,
    output logic [ANGLE_BITS-1:0] o_rh,
    output logic                  o_sat
);

    localparam int PRW = 33 + TW;   // product width
    localparam int AW  = PRW + 1;   // accumulator width
    localparam int RW  = AW - TRIG_SHIFT;
    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (TRIG_SHIFT - 1);
    localparam logic signed [RW-1:0] MAXV = RW'(64'sd2147483647);
    localparam logic signed [RW-1:0] MINV = -RW'(64'sd2147483648);

    // stage 1: quadrant fold
    logic                  r_v1;
    logic signed [TW-1:0]  r_c, r_s, n_c, n_s;
    t_pay                  r_p1;
    logic [ANGLE_BITS-1:0] r_h1;

    always_comb begin
        case (i_pay.quad)
            2'd0: begin n_c = i_x;  n_s = i_y;  end
            2'd1: begin n_c = -i_y; n_s = i_x;  end
            2'd2: begin n_c = -i_x; n_s = -i_y; end
            default: begin n_c = i_y; n_s = -i_x; end
        endcase
    end

    // stage 2: products
    logic                   r_v2;
    logic signed [PRW-1:0]  r_ec, r_fs, r_es, r_fc;
    t_pay                   r_p2;
    logic [ANGLE_BITS-1:0]  r_h2;

    // stage 3: signed pair sums
    logic                   r_v3;
    logic signed [AW-1:0]   r_sx, r_sy, n_sx, n_sy;
    t_pay                   r_p3;
    logic [ANGLE_BITS-1:0]  r_h3;

    always_comb begin
        case (r_p2.op)
            OP_COMPOSE: begin
                n_sx = AW'(r_ec) - AW'(r_fs);
                n_sy = AW'(r_es) + AW'(r_fc);
            end
            OP_INVERSE: begin
                n_sx = -AW'(r_ec) - AW'(r_fs);
                n_sy = AW'(r_es) - AW'(r_fc);
            end
            OP_RELATIVE: begin
                n_sx = AW'(r_ec) + AW'(r_fs);
                n_sy = AW'(r_fc) - AW'(r_es);
            end
            default: begin
                n_sx = '0;
                n_sy = '0;
            end
        endcase
    end

    // stage 4: offset and rounding bias
    logic                   r_v4;
    logic signed [AW-1:0]   r_ax, r_ay;
    logic                   r_z4;
    logic [ANGLE_BITS-1:0]  r_h4;

    // stage 5: output register
    logic                   r_v5;
    logic [31:0]            r_rx, r_ry, n_rx, n_ry;
    logic [ANGLE_BITS-1:0]  r_h5;
    logic                   r_sat, n_sat;
    logic signed [RW-1:0]   w_qx, w_qy;

    assign w_qx = r_ax[AW-1:TRIG_SHIFT];
    assign w_qy = r_ay[AW-1:TRIG_SHIFT];

    always_comb begin
        n_sat = 1'b0;
        if (w_qx > MAXV) begin
            n_rx = 32'h7fff_ffff; n_sat = 1'b1;
        end else if (w_qx < MINV) begin
            n_rx = 32'h8000_0000; n_sat = 1'b1;
        end else begin
            n_rx = w_qx[31:0];
        end
        if (w_qy > MAXV) begin
            n_ry = 32'h7fff_ffff; n_sat = 1'b1;
        end else if (w_qy < MINV) begin
            n_ry = 32'h8000_0000; n_sat = 1'b1;
        end else begin
            n_ry = w_qy[31:0];
        end
        if (r_z4) begin
            n_rx = '0; n_ry = '0; n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c  <= n_c;
            r_s  <= n_s;
            r_p1 <= i_pay;
            r_h1 <= i_rh;
            r_ec <= PRW'(r_p1.e * r_c);
            r_fs <= PRW'(r_p1.f * r_s);
            r_es <= PRW'(r_p1.e * r_s);
            r_fc <= PRW'(r_p1.f * r_c);
            r_p2 <= r_p1;
            r_h2 <= r_h1;
            r_sx <= n_sx;
            r_sy <= n_sy;
            r_p3 <= r_p2;
            r_h3 <= r_h2;
            r_ax <= r_sx + (AW'(r_p3.p) <<< TRIG_SHIFT) + HALF;
            r_ay <= r_sy + (AW'(r_p3.q) <<< TRIG_SHIFT) + HALF;
            r_z4 <= (r_p3.op != OP_COMPOSE) && (r_p3.op != OP_INVERSE)
                    && (r_p3.op != OP_RELATIVE);
            r_h4 <= r_h3;
            r_rx <= n_rx;
            r_ry <= n_ry;
            r_sat <= n_sat;
            r_h5 <= r_h4;
        end
    end

    assign o_valid = r_v5;
    assign o_rx    = r_rx;
    assign o_ry    = r_ry;
    assign o_rh    = r_h5;
    assign o_sat   = r_sat;

endmodule

### src/planar_pose_compose.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// planar_pose_compose
// se(2) pose compose / inverse / relative with cordic trig and saturation
// ---------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                         tuser
// s_axis   in   ax, ay, a_heading, bx, by, b_heading       op
// m_axis   out  rx, ry, r_heading                          saturated
//
// one transaction in and one out per cycle when not stalled
// pipeline: 28 cordic micro-rotation stages, then quadrant fold,
// multiply, pair sum, offset add, round/saturate into the output register
// whole pipe advances together; it holds while the output register is full
// and not taken, so s_axis tready follows the output side
// synchronous active-low reset clears the valid bits only
// ---------------------------------------------------------------------------
module planar_pose_compose import ppc_pkg::*; #(
    parameter int ANGLE_BITS = PPC_ANGLE_BITS,
    localparam int IN_W  = ((128 + 2 * ANGLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((64 + ANGLE_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,  // ax, ay, a_heading, bx, by, b_heading
    input  logic [1:0]       i_s_axis_tuser,  // op
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,  // rx, ry, r_heading
    output logic             o_m_axis_tuser   // saturated
);

    localparam int PW = $bits(t_pay) + ANGLE_BITS;

    logic                  w_en;
    logic signed [31:0]    w_ax, w_ay, w_bx, w_by;
    logic [ANGLE_BITS-1:0] w_ah, w_bh, w_rh;
    logic [31:0]           w_a32, w_rnd, w_res;
    logic signed [ZW-1:0]  w_z;
    t_pay                  w_pay, w_cpay;
    logic [ANGLE_BITS-1:0] w_crh, w_orh;
    logic                  w_cv, w_sat;
    logic signed [TW-1:0]  w_cx, w_cy;
    logic [31:0]           w_rx, w_ry;

    // pipe moves whenever the output slot is free or being taken
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // field unpack
    assign w_ax = i_s_axis_tdata[31:0];
    assign w_ay = i_s_axis_tdata[63:32];
    assign w_ah = i_s_axis_tdata[64 +: ANGLE_BITS];
    assign w_bx = i_s_axis_tdata[64 + ANGLE_BITS +: 32];
    assign w_by = i_s_axis_tdata[96 + ANGLE_BITS +: 32];
    assign w_bh = i_s_axis_tdata[128 + ANGLE_BITS +: ANGLE_BITS];

    // heading to 32-bit turn, nearest quadrant and residual in [-1/8, 1/8)
    assign w_a32 = {w_ah, {(32 - ANGLE_BITS){1'b0}}};
    assign w_rnd = w_a32 + 32'h2000_0000;
    assign w_res = w_a32 - {w_rnd[31:30], 30'd0};
    assign w_z   = {w_res[31], w_res};

    // operand selection: e,f get rotated, p,q are the untouched offset
    always_comb begin
        w_pay.op   = i_s_axis_tuser;
        w_pay.quad = w_rnd[31:30];
        w_pay.p    = '0;
        w_pay.q    = '0;
        case (i_s_axis_tuser)
            OP_COMPOSE: begin
                w_pay.e = 33'(w_bx);
                w_pay.f = 33'(w_by);
                w_pay.p = w_ax;
                w_pay.q = w_ay;
                w_rh    = w_ah + w_bh;
            end
            OP_INVERSE: begin
                w_pay.e = 33'(w_ax);
                w_pay.f = 33'(w_ay);
                w_rh    = -w_ah;
            end
            OP_RELATIVE: begin
                w_pay.e = 33'(w_bx) - 33'(w_ax);
                w_pay.f = 33'(w_by) - 33'(w_ay);
                w_rh    = w_bh - w_ah;
            end
            default: begin
                w_pay.e = '0;
                w_pay.f = '0;
                w_rh    = '0;
            end
        endcase
    end

    ppc_cordic #(.PW(PW)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_z     (w_z),
        .i_pay   ({w_rh, w_pay}),
        .o_valid (w_cv),
        .o_x     (w_cx),
        .o_y     (w_cy),
        .o_pay   ({w_crh, w_cpay})
    );

    ppc_combine #(.ANGLE_BITS(ANGLE_BITS)) u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cv),
        .i_x     (w_cx),
        .i_y     (w_cy),
        .i_pay   (w_cpay),
        .i_rh    (w_crh),
        .o_valid (o_m_axis_tvalid),
        .o_rx    (w_rx),
        .o_ry    (w_ry),
        .o_rh    (w_orh),
        .o_sat   (w_sat)
    );

    assign o_m_axis_tdata = OUT_W'({w_orh, w_ry, w_rx});
    assign o_m_axis_tuser = w_sat;

endmodule

### src/ppc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppc_checker
// port-level checks on the pose pipeline, bound to the top level
// ---------------------------------------------------------------------------
`include "planar_pose_compose_defines.svh"

module ppc_checker import ppc_pkg::*; #(
    parameter int ANGLE_BITS = PPC_ANGLE_BITS,
    localparam int IN_W  = ((128 + 2 * ANGLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((64 + ANGLE_BITS + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic [IN_W-1:0]  i_s_axis_tdata,
    input logic [1:0]       i_s_axis_tuser,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic             o_m_axis_tuser
);

    logic [31:0] w_rx, w_ry;
    logic        w_rail;

    assign w_rx   = o_m_axis_tdata[31:0];
    assign w_ry   = o_m_axis_tdata[63:32];
    assign w_rail = (w_rx == 32'h7fff_ffff) || (w_rx == 32'h8000_0000)
                    || (w_ry == 32'h7fff_ffff) || (w_ry == 32'h8000_0000);

    // stalled result stays offered
    `PPC_ASSERT_NEXT(a_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)

    // stalled result keeps its payload
    `PPC_ASSERT_NEXT(a_out_stable, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // empty output slot never blocks the input side
    `PPC_ASSERT_NOW(a_ready, !o_m_axis_tvalid, o_s_axis_tready)

    // offered input transaction carries known fields
    `PPC_ASSERT_NOW(a_in_known, i_s_axis_tvalid, !$isunknown({i_s_axis_tuser, i_s_axis_tdata}))

    // saturation flag means a coordinate sits on a rail
    `PPC_ASSERT_NOW(a_sat_rail, o_m_axis_tvalid && o_m_axis_tuser, w_rail)

endmodule

bind planar_pose_compose ppc_checker #(.ANGLE_BITS(ANGLE_BITS)) u_ppc_checker (.*);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// testbench for planar_pose_compose: compose, inverse, relative and unused op
// through the stream ports, results checked against an in-bench cordic model
// ---------------------------------------------------------------------------
module tb;
    import ppc_pkg::*;

    localparam int N_RANDOM  = 450;
    localparam int STALL_AT  = 120;   // accepted count that starts the long receiver stall
    localparam int STALL_LEN = 300;
    localparam int PAUSE_AT  = 300;   // accepted count where the sender waits for a full drain
    localparam int DRAIN_WAIT = 40;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         op;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic [15:0]        ah;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic [15:0]        bh;
    } pose_pair_t;

    typedef struct {
        logic [31:0] rx;
        logic [31:0] ry;
        logic [15:0] rh;
        logic        sat;
    } pose_result_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;   // ax, ay, a_heading, bx, by, b_heading
    logic [1:0]   s_tuser = '0;   // op
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;        // rx, ry, r_heading
    logic         m_tuser;        // saturated

    pose_pair_t   pending_q[$];
    pose_result_t expected_q[$];
    int           n_accepted = 0;
    int           n_results = 0;
    int           n_errors = 0;
    int           n_sat = 0;
    int           n_items = 0;
    int           op_count[4] = '{0, 0, 0, 0};

    planar_pose_compose u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // arctangent of 2^-i in 2^-32 turn units
    const longint atan_lut[28] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };

    // cos/sin of a heading in q2.30: nearest quadrant, cordic on the residual
    function automatic void heading_trig(input logic [15:0] h,
                                         output longint c, output longint s);
        logic [31:0] a32;
        logic [31:0] res;
        logic [1:0]  quad;
        longint      x, y, z, dx, dy;
        a32  = {h, 16'h0000};
        quad = 2'((a32 + 32'h2000_0000) >> 30);
        res  = a32 - ({30'b0, quad} << 30);
        z    = longint'(signed'(res));
        x    = 652032874;
        y    = 0;
        for (int i = 0; i < 28; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_lut[i];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_lut[i];
            end
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    // round half up out of q.30 and clamp to signed 32 bits
    function automatic logic [31:0] round_clamp(input longint acc, inout logic sat);
        longint r;
        r = (acc + (64'sd1 <<< 29)) >>> 30;
        if (r > 64'sd2147483647) begin
            sat = 1'b1;
            r = 64'sd2147483647;
        end else if (r < -64'sd2147483648) begin
            sat = 1'b1;
            r = -64'sd2147483648;
        end
        return r[31:0];
    endfunction

    function automatic pose_result_t pose_predict(input pose_pair_t p);
        pose_result_t e;
        longint c, s, ax, ay, bx, by, dx, dy;
        logic   sat;
        sat = 1'b0;
        e = '{32'h0, 32'h0, 16'h0, 1'b0};
        heading_trig(p.ah, c, s);
        ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
        case (p.op)
            OP_COMPOSE: begin
                e.rx = round_clamp((ax <<< 30) + bx * c - by * s, sat);
                e.ry = round_clamp((ay <<< 30) + bx * s + by * c, sat);
                e.rh = p.ah + p.bh;
            end
            OP_INVERSE: begin
                e.rx = round_clamp(-(ax * c) - ay * s, sat);
                e.ry = round_clamp(ax * s - ay * c, sat);
                e.rh = 16'h0 - p.ah;
            end
            OP_RELATIVE: begin
                dx = bx - ax;
                dy = by - ay;
                e.rx = round_clamp(dx * c + dy * s, sat);
                e.ry = round_clamp(dy * c - dx * s, sat);
                e.rh = p.bh - p.ah;
            end
            default: ;   // unused op gives all zeros
        endcase
        e.sat = sat;
        return e;
    endfunction

    // coordinate mix: extremes, small values near zero, and full-range random
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    // mostly short gaps, some long ones; every third block of 50 runs gapless
    function automatic int pick_gap(input int count);
        int r;
        if ((count / 50) % 3 == 1)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_pair(input logic [1:0] op, input logic [31:0] ax, input logic [31:0] ay,
                            input logic [15:0] ah, input logic [31:0] bx,
                            input logic [31:0] by, input logic [15:0] bh);
        pose_pair_t p;
        p = '{op, ax, ay, ah, bx, by, bh};
        pending_q.push_back(p);
    endtask

    // stimulus: directed corners first, then random pose pairs
    initial begin
        logic [1:0] op;
        // heading 0 and quadrant points, for compose, inverse and relative
        add_pair(OP_COMPOSE, 32'h0001_0000, 32'h0002_0000, 16'h0000,
                 32'h0003_0000, 32'hFFFF_0000, 16'h4000);
        add_pair(OP_COMPOSE, 32'h0001_0000, 32'h0002_0000, 16'h4000,
                 32'h0003_0000, 32'hFFFF_0000, 16'hC000);
        add_pair(OP_INVERSE, 32'h0005_8000, 32'hFFFA_0000, 16'h8000,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_pair(OP_RELATIVE, 32'h0001_0000, 32'h0001_0000, 16'hC000,
                 32'h0004_0000, 32'h0000_0000, 16'h1234);
        // quadrant split points and the top heading
        add_pair(OP_COMPOSE, 32'h0, 32'h0, 16'h2000, 32'h0001_0000, 32'h0, 16'hFFFF);
        add_pair(OP_COMPOSE, 32'h0, 32'h0, 16'h1FFF, 32'h0001_0000, 32'h0, 16'h0001);
        add_pair(OP_RELATIVE, 32'h0, 32'h0, 16'hFFFF, 32'h0001_0000, 32'h0001_0000, 16'h0000);
        add_pair(OP_INVERSE, 32'h0, 32'h0, 16'hE000, 32'h0, 32'h0, 16'h0);
        // saturation both ways
        add_pair(OP_COMPOSE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000);
        add_pair(OP_COMPOSE, 32'h8000_0000, 32'h8000_0000, 16'h0000,
                 32'h8000_0000, 32'h8000_0000, 16'h8000);
        add_pair(OP_RELATIVE, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
        add_pair(OP_INVERSE, 32'h8000_0000, 32'h8000_0000, 16'h2000,
                 32'h0, 32'h0, 16'h0);
        add_pair(OP_INVERSE, 32'h7FFF_FFFF, 32'h8000_0000, 16'h6000,
                 32'h1234_5678, 32'h9ABC_DEF0, 16'hAAAA);
        // unused op, with busy fields
        add_pair(OP_UNUSED, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        add_pair(OP_UNUSED, 32'h0, 32'h0, 16'h0, 32'h0, 32'h0, 16'h0);
        // all-ones and alternating bit patterns
        add_pair(OP_RELATIVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_pair(OP_COMPOSE, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555,
                 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA);
        for (int i = 0; i < N_RANDOM; i++) begin
            op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
            add_pair(op, pick_coord(), pick_coord(), 16'($urandom), pick_coord(),
                     pick_coord(), 16'($urandom));
        end
        n_items = pending_q.size();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver: offers pending pairs, records each accepted transaction
    always @(posedge i_clk) begin
        pose_pair_t p;
        static int  gap = 0;
        static bit  paused_done = 0;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                expected_q.push_back(pose_predict(p));
                op_count[p.op]++;
                n_accepted++;
            end
            // one pause that lets the whole pipe drain
            if (n_accepted == PAUSE_AT && !paused_done && expected_q.size() != 0) begin
                s_tvalid <= 1'b0;
            end else if (gap > 0) begin
                if (n_accepted == PAUSE_AT) paused_done = 1;
                gap--;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                if (n_accepted == PAUSE_AT) paused_done = 1;
                p = pending_q.pop_front();
                s_tdata  <= {p.bh, p.by, p.bx, p.ah, p.ay, p.ax};
                s_tuser  <= p.op;
                s_tvalid <= 1'b1;
                gap = pick_gap(n_accepted);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: random receiver stalls plus one long hold-off, checks every transaction
    always @(posedge i_clk) begin
        pose_result_t e;
        static int  stall = 0;
        static bit  long_done = 0;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (m_tuser) n_sat++;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result rx=%h ry=%h rh=%h sat=%b", $time,
                             m_tdata[31:0], m_tdata[63:32], m_tdata[79:64], m_tuser);
                    n_errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (m_tdata[31:0] !== e.rx || m_tdata[63:32] !== e.ry ||
                        m_tdata[79:64] !== e.rh || m_tuser !== e.sat) begin
                        $display("%0t: mismatch expected rx=%h ry=%h rh=%h sat=%b", $time,
                                 e.rx, e.ry, e.rh, e.sat);
                        $display("%0t:          actual   rx=%h ry=%h rh=%h sat=%b", $time,
                                 m_tdata[31:0], m_tdata[63:32], m_tdata[79:64], m_tuser);
                        n_errors++;
                    end
                end
            end
            if (!long_done && n_accepted >= STALL_AT) begin
                long_done = 1;
                stall = STALL_LEN;
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall = pick_gap(n_results + 25);
            end
        end
    end

    // end of run: all accepted, all results back, then a short drain
    initial begin
        wait (i_rst_n);
        while (n_items == 0 || n_accepted < n_items || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("pairs sent %0d (compose %0d, inverse %0d, relative %0d, unused %0d)",
                 n_accepted, op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("results checked %0d, saturated %0d, errors %0d", n_results, n_sat, n_errors);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout: accepted %0d of %0d, %0d results outstanding",
                 n_accepted, n_items, expected_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/ppc_pkg.sv
src/ppc_cordic.sv
src/ppc_combine.sv
src/planar_pose_compose.sv
src/ppc_checker.sv
tb/sv/tb.sv
